>>> src/aavr_pkg.sv
// aavr_pkg: shared constants, types and cordic tables for the axis-angle rotation block
// no dependencies
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int VecWidthDefault   = 24;
  localparam int AngleWidthDefault = 16;
  localparam int AxisWidth         = 16;
  localparam int CordicSteps       = 16;
  localparam int CordicW           = 34;  // x, y, z of the cordic in two's complement
  localparam int CosW              = 16;  // q1.14 clamped values fit in 16 bits
  localparam int EntryW            = 29;  // rounded matrix entries, units of 2^-24

  localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

  function automatic logic signed [CordicW-1:0] atan_val(input logic [3:0] idx);
    logic signed [CordicW-1:0] r;
    begin
      case (idx)
        4'd0:  r = 34'sd536870912;
        4'd1:  r = 34'sd316933406;
        4'd2:  r = 34'sd167458907;
        4'd3:  r = 34'sd85004756;
        4'd4:  r = 34'sd42667331;
        4'd5:  r = 34'sd21354465;
        4'd6:  r = 34'sd10679838;
        4'd7:  r = 34'sd5340245;
        4'd8:  r = 34'sd2670163;
        4'd9:  r = 34'sd1335087;
        4'd10: r = 34'sd667544;
        4'd11: r = 34'sd333772;
        4'd12: r = 34'sd166886;
        4'd13: r = 34'sd83443;
        4'd14: r = 34'sd41722;
        4'd15: r = 34'sd20861;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      neg;
  } cordic_t;

endpackage

>>> src/axis_angle_vector_rotation.sv
// axis_angle_vector_rotation: rodrigues rotation of a vector about a unit axis
// depends on aavr_pkg and aavr_sincos
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready axis_* turn_angle vec_* | sink
//  out     | out_valid out_ready out_x out_y out_z     | source
//
// one beat per cycle while the output is not stalled; 17 cordic + rounding, then 6 matrix/product stages
// the whole pipeline advances only when its last stage is empty or being taken
// a stall freezes every stage, so nothing is lost or repeated
// synchronous reset clears valid bits only; no state between beats
`timescale 1ns / 1ps
module axis_angle_vector_rotation import aavr_pkg::*; #(
  parameter int VEC_WIDTH   = VecWidthDefault,
  parameter int ANGLE_WIDTH = AngleWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [AxisWidth-1:0]   axis_x,
  input  logic signed [AxisWidth-1:0]   axis_y,
  input  logic signed [AxisWidth-1:0]   axis_z,
  input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
  input  logic signed [VEC_WIDTH-1:0]   vec_x,
  input  logic signed [VEC_WIDTH-1:0]   vec_y,
  input  logic signed [VEC_WIDTH-1:0]   vec_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VEC_WIDTH-1:0]   out_x,
  output logic signed [VEC_WIDTH-1:0]   out_y,
  output logic signed [VEC_WIDTH-1:0]   out_z
);

  localparam int SideW = 3*AxisWidth + 3*VEC_WIDTH;
  localparam int PairW = 2*AxisWidth;          // ni*nj
  localparam int TermW = 52;                   // entry terms, units of 2^-42
  localparam int ProdW = EntryW + VEC_WIDTH;   // entry times component
  localparam int AccW  = ProdW + 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                   sc_valid;
  logic signed [CosW-1:0] cq, sq;
  logic [SideW-1:0]       side_o;

  aavr_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .SIDE_W(SideW)) u_sincos (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .angle    (turn_angle),
    .side_in  ({axis_x, axis_y, axis_z, vec_x, vec_y, vec_z}),
    .out_valid(sc_valid),
    .cos_q    (cq),
    .sin_q    (sq),
    .side_out (side_o)
  );

  logic signed [AxisWidth-1:0] ax, ay, az;
  logic signed [VEC_WIDTH-1:0] vx, vy, vz;
  assign {ax, ay, az, vx, vy, vz} = side_o;

  // stage a: axis products, omc, sine products
  logic [5:0] vld;
  logic signed [PairW-1:0]   p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic signed [PairW:0]     s_x, s_y, s_z;         // nk*s, q2.28
  logic signed [CosW:0]      omc_a;
  logic signed [CosW-1:0]    cos_a;
  logic signed [VEC_WIDTH-1:0] va_x, va_y, va_z;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[4:0], sc_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx  <= ax * ax;  p_yy <= ay * ay;  p_zz <= az * az;
      p_xy  <= ax * ay;  p_xz <= ax * az;  p_yz <= ay * az;
      s_x   <= (PairW+1)'(ax) * (PairW+1)'(sq);
      s_y   <= (PairW+1)'(ay) * (PairW+1)'(sq);
      s_z   <= (PairW+1)'(az) * (PairW+1)'(sq);
      omc_a <= (CosW+1)'(17'sd16384 - (CosW+1)'(cq));
      cos_a <= cq;
      va_x  <= vx; va_y <= vy; va_z <= vz;
    end
  end

  // stage b: pair times omc, with the cosine and sine terms shifted to the same units
  logic signed [TermW-1:0] t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, cb_b;
  logic signed [TermW-1:0] k_x, k_y, k_z;
  logic signed [VEC_WIDTH-1:0] vb_x, vb_y, vb_z;

  always_ff @(posedge clk) begin
    if (en) begin
      t_xx <= TermW'(p_xx) * TermW'(omc_a);
      t_yy <= TermW'(p_yy) * TermW'(omc_a);
      t_zz <= TermW'(p_zz) * TermW'(omc_a);
      t_xy <= TermW'(p_xy) * TermW'(omc_a);
      t_xz <= TermW'(p_xz) * TermW'(omc_a);
      t_yz <= TermW'(p_yz) * TermW'(omc_a);
      cb_b <= TermW'(cos_a) <<< 28;
      k_x  <= TermW'(s_x) <<< 14;
      k_y  <= TermW'(s_y) <<< 14;
      k_z  <= TermW'(s_z) <<< 14;
      vb_x <= va_x; vb_y <= va_y; vb_z <= va_z;
    end
  end

  // stage c: entries, rounded
  function automatic logic signed [EntryW-1:0] rnd_e(input logic signed [TermW-1:0] v);
    logic signed [TermW-1:0] t;
    begin
      t = (v + TermW'(131072)) >>> 18;
      return EntryW'(t);
    end
  endfunction

  logic signed [EntryW-1:0] r [3][3];
  logic signed [VEC_WIDTH-1:0] vc_x, vc_y, vc_z;

  always_ff @(posedge clk) begin
    if (en) begin
      r[0][0] <= rnd_e(cb_b + t_xx);
      r[0][1] <= rnd_e(t_xy - k_z);
      r[0][2] <= rnd_e(t_xz + k_y);
      r[1][0] <= rnd_e(t_xy + k_z);
      r[1][1] <= rnd_e(cb_b + t_yy);
      r[1][2] <= rnd_e(t_yz - k_x);
      r[2][0] <= rnd_e(t_xz - k_y);
      r[2][1] <= rnd_e(t_yz + k_x);
      r[2][2] <= rnd_e(cb_b + t_zz);
      vc_x <= vb_x; vc_y <= vb_y; vc_z <= vb_z;
    end
  end

  // stage d: products
  logic signed [ProdW-1:0] m [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        m[i][0] <= ProdW'(r[i][0]) * ProdW'(vc_x);
        m[i][1] <= ProdW'(r[i][1]) * ProdW'(vc_y);
        m[i][2] <= ProdW'(r[i][2]) * ProdW'(vc_z);
      end
    end
  end

  // stage e: row sums
  logic signed [AccW-1:0] acc [3];
  for (genvar i = 0; i < 3; i++) begin : g_acc
    always_ff @(posedge clk) begin
      if (en) acc[i] <= AccW'(m[i][0]) + AccW'(m[i][1]) + AccW'(m[i][2]);
    end
  end

  // stage f: round and saturate
  localparam logic signed [AccW-1:0] VMax = AccW'((64'sd1 <<< (VEC_WIDTH-1)) - 1);
  localparam logic signed [AccW-1:0] VMin = -VMax - AccW'(1);

  function automatic logic signed [VEC_WIDTH-1:0] fin(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] t;
    begin
      t = (a + AccW'(64'sd8388608)) >>> 24;
      if (t > VMax) t = VMax;
      if (t < VMin) t = VMin;
      return VEC_WIDTH'(t);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= fin(acc[0]);
      out_y <= fin(acc[1]);
      out_z <= fin(acc[2]);
    end
  end

  // vld[5] spare stage bit tracks nothing beyond output; keep it consistent
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    en |=> (out_valid == $past(vld[4]))) else $error("output valid lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("pipeline moved on stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    en |=> (vld[5] == $past(vld[4]))) else $error("valid chain broken");

endmodule

>>> src/aavr_sincos.sv
// aavr_sincos: pipelined 16-step rotation cordic, one step per stage, plus rounding stage
// depends on aavr_pkg; carries a side payload of width SIDE_W alongside each item
`timescale 1ns / 1ps
module aavr_sincos import aavr_pkg::*; #(
  parameter int ANGLE_WIDTH = AngleWidthDefault,
  parameter int SIDE_W      = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic signed [CosW-1:0]        cos_q,
  output logic signed [CosW-1:0]        sin_q,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int NStage = CordicSteps + 1;

  cordic_t            st    [NStage];
  logic [SIDE_W-1:0]  sd    [NStage];
  logic [NStage-1:0]  vld;
  cordic_t            init_c;
  logic [31:0]        a32;
  logic signed [CordicW-1:0] z0;

  always_comb begin
    a32 = {angle, {(32-ANGLE_WIDTH){1'b0}}};
    z0  = CordicW'(signed'(a32));
    init_c.x   = CordicX0;
    init_c.y   = '0;
    init_c.neg = 1'b0;
    init_c.z   = z0;
    if (z0 > 34'sd1073741824) begin
      init_c.z   = z0 - 34'sd2147483648;
      init_c.neg = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      init_c.z   = z0 + 34'sd2147483648;
      init_c.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NStage-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= init_c;
      sd[0] <= side_in;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cordic_t nxt;
    always_comb begin
      nxt = st[i];
      if (st[i].z >= 0) begin
        nxt.x = st[i].x - (st[i].y >>> i);
        nxt.y = st[i].y + (st[i].x >>> i);
        nxt.z = st[i].z - atan_val(4'(i));
      end else begin
        nxt.x = st[i].x + (st[i].y >>> i);
        nxt.y = st[i].y - (st[i].x >>> i);
        nxt.z = st[i].z + atan_val(4'(i));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
        sd[i+1] <= sd[i];
      end
    end
  end

  // round to q1.14 and clamp
  function automatic logic signed [CosW-1:0] rnd(input logic signed [CordicW-1:0] v,
                                                 input logic neg);
    logic signed [CordicW-1:0] t;
    logic signed [CosW-1:0]    c;
    begin
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) c = 16'sd16384;
      else if (t < -34'sd16384) c = -16'sd16384;
      else c = CosW'(t);
      return neg ? -c : c;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NStage-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q    <= rnd(st[NStage-1].x, st[NStage-1].neg);
      sin_q    <= rnd(st[NStage-1].y, st[NStage-1].neg);
      side_out <= sd[NStage-1];
    end
  end

endmodule

>>> bench/aavr_checker.sv
// aavr_checker: watches both channels of the axis-angle rotation block, predicts and compares
// depends on aavr_pkg for the widths
`timescale 1ns / 1ps
module aavr_checker import aavr_pkg::*; #(
  parameter int VEC_WIDTH   = VecWidthDefault,
  parameter int ANGLE_WIDTH = AngleWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [AxisWidth-1:0]   axis_x,
  input  logic signed [AxisWidth-1:0]   axis_y,
  input  logic signed [AxisWidth-1:0]   axis_z,
  input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
  input  logic signed [VEC_WIDTH-1:0]   vec_x,
  input  logic signed [VEC_WIDTH-1:0]   vec_y,
  input  logic signed [VEC_WIDTH-1:0]   vec_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [VEC_WIDTH-1:0]   out_x,
  input  logic signed [VEC_WIDTH-1:0]   out_y,
  input  logic signed [VEC_WIDTH-1:0]   out_z,
  output int                            fail_count,
  output int                            pending
);

  typedef struct {
    logic signed [VEC_WIDTH-1:0] x;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] z;
  } vec3_t;

  vec3_t rotated_q[$];

  localparam longint ArcTab[16] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  function automatic longint q14_clip(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void angle_sincos(logic [ANGLE_WIDTH-1:0] ang, output longint c,
                                       output longint s);
    logic [31:0] a32;
    longint z, x, y, dx, dy;
    bit flip;
    a32 = 32'(ang) << (32 - ANGLE_WIDTH);
    z = longint'($signed(a32));
    flip = 0;
    x = 652032874;
    y = 0;
    // fold the outer half-circle onto the cordic's range
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    c = q14_clip((x + 32768) >>> 16);
    s = q14_clip((y + 32768) >>> 16);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] sat_out(longint acc);
    longint r, hi;
    r = (acc + 64'sd8388608) >>> 24;
    hi = (64'sd1 <<< (VEC_WIDTH - 1)) - 1;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[VEC_WIDTH-1:0];
  endfunction

  function automatic vec3_t rodrigues(longint nx, longint ny, longint nz,
                                      logic [ANGLE_WIDTH-1:0] ang,
                                      longint vx, longint vy, longint vz);
    longint c, s, omc, cb, m[3][3];
    vec3_t r;
    angle_sincos(ang, c, s);
    omc = 16384 - c;
    cb = c * 268435456;
    m[0][0] = cb + nx * nx * omc;
    m[0][1] = nx * ny * omc - nz * s * 16384;
    m[0][2] = nx * nz * omc + ny * s * 16384;
    m[1][0] = ny * nx * omc + nz * s * 16384;
    m[1][1] = cb + ny * ny * omc;
    m[1][2] = ny * nz * omc - nx * s * 16384;
    m[2][0] = nz * nx * omc - ny * s * 16384;
    m[2][1] = nz * ny * omc + nx * s * 16384;
    m[2][2] = cb + nz * nz * omc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (m[i][j] + 131072) >>> 18;
    r.x = sat_out(m[0][0] * vx + m[0][1] * vy + m[0][2] * vz);
    r.y = sat_out(m[1][0] * vx + m[1][1] * vy + m[1][2] * vz);
    r.z = sat_out(m[2][0] * vx + m[2][1] * vy + m[2][2] * vz);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    vec3_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        rotated_q.push_back(rodrigues(axis_x, axis_y, axis_z, turn_angle, vec_x, vec_y, vec_z));
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = rotated_q.pop_front();
          if (out_x !== e.x) report("out_x", out_x, e.x);
          if (out_y !== e.y) report("out_y", out_y, e.y);
          if (out_z !== e.z) report("out_z", out_z, e.z);
        end
      end
    end
    pending = rotated_q.size();
  end

endmodule

>>> bench/tb_axis_angle_vector_rotation.sv
// tb_axis_angle_vector_rotation: stimulus and verdict for the axis-angle rotation block
// depends on aavr_pkg, axis_angle_vector_rotation and aavr_checker
`timescale 1ns / 1ps
module tb_axis_angle_vector_rotation import aavr_pkg::*;;

  localparam int VW = VecWidthDefault;
  localparam int AW = AngleWidthDefault;
  localparam int RandItems = 2000;
  localparam int CalmTail = 300;
  localparam int CycleLimit = 400000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [AxisWidth-1:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [AW-1:0] turn_angle = '0;
  logic signed [VW-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [VW-1:0] out_x, out_y, out_z;
  int fail_count, pending, cycles = 0;
  bit calm = 0, hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  axis_angle_vector_rotation #(.VEC_WIDTH(VW), .ANGLE_WIDTH(AW)) uut (.*);
  aavr_checker #(.VEC_WIDTH(VW), .ANGLE_WIDTH(AW)) chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_axis_angle_vector_rotation: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic signed [AxisWidth-1:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return AxisWidth'($urandom);            // any code, non-unit axes
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return AxisWidth'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_vec();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(VW-1){1'b1}}};
      1: return {1'b1, {(VW-1){1'b0}}};
      2: return VW'($urandom_range(0, 2000) - 1000);
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic send(logic signed [AxisWidth-1:0] ax, ay, az, logic signed [AW-1:0] ang,
                      logic signed [VW-1:0] vx, vy, vz);
    in_valid <= 1;
    axis_x <= ax; axis_y <= ay; axis_z <= az; turn_angle <= ang;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    @(posedge clk iff in_ready);
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 7);
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic signed [AW-1:0] dir_angles[8];
    int tail;
    dir_angles = '{16'sh0000, 16'sh4000, -16'sh4000, -16'sh8000,
                   16'sh7fff, 16'sh0001, 16'shffff, 16'sh2000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: axis and angle extremes, quarter turns, minus pi, saturation
    foreach (dir_angles[i])
      send(16'sd0, 16'sd0, 16'sd16384, dir_angles[i], 24'sd1000, -24'sd2000, 24'sd3000);
    send(16'sd16384, 16'sd0, 16'sd0, 16'sh4000, 24'sd8388607, -24'sd8388608, 24'sd5);
    send(16'sd0, -16'sd16384, 16'sd0, -16'sh8000, -24'sd8388608, 24'sd8388607, -24'sd1);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh1234, 24'sd8388607, 24'sd8388607, 24'sd8388607);
    send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh5555, -24'sd8388608, -24'sd8388608,
         -24'sd8388608);
    send(16'sd9459, 16'sd9459, 16'sd9459, 16'sh2aaa, 24'sd100, 24'sd200, 24'sd300);
    send(16'sd0, 16'sd0, 16'sd0, 16'sh3000, 24'sd4000000, 24'sd4000000, 24'sd4000000);
    // random part, with a long receiver hold-off partway through
    for (int i = 0; i < RandItems; i++) begin
      if (i == 500) hold_off = 1;
      idle_gap();
      send(pick_axis(), pick_axis(), pick_axis(), AW'($urandom), pick_vec(), pick_vec(),
           pick_vec());
    end
    calm = 1;
    for (int i = 0; i < CalmTail; i++)
      send(pick_axis(), pick_axis(), pick_axis(), AW'($urandom), pick_vec(), pick_vec(),
           pick_vec());
    in_valid <= 0;
    @(posedge clk iff pending == 0);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end
    if (fail_count == 0)
      $display("tb_axis_angle_vector_rotation: done, clean");
    else
      $display("tb_axis_angle_vector_rotation: done, errors");
    $finish;
  end

endmodule
